/* sv/cci_pkg.sv */
// Shared types, status codes and arithmetic step functions for the
// circle-circle intersection block. No dependencies.
package cci_pkg;

	localparam int MQ_DEPTH = 4;
	localparam int MQ_AW = $clog2(MQ_DEPTH);
	localparam logic [15:0] TOL_RESET = 16'd1;

	typedef enum logic [1:0] {
		ST_APART   = 2'd0,
		ST_TANGENT = 2'd1,
		ST_TWO     = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic [30:0]        first_radius;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic [30:0]        second_radius;
	} in_t;

	typedef struct packed {
		logic signed [31:0] point_a_x;
		logic signed [31:0] point_a_y;
		logic signed [31:0] point_b_x;
		logic signed [31:0] point_b_y;
		status_t            status;
	} out_t;

	// classified word passed from front to back
	typedef struct packed {
		logic [31:0] x1;
		logic [31:0] y1;
		logic [30:0] r1;
		logic [32:0] dx;
		logic [32:0] dy;
		logic [32:0] d;
		logic [31:0] dr;
		logic [31:0] s;
		status_t     status;
	} mid_t;

	typedef struct packed {
		logic [35:0] rem;
		logic [32:0] root;
	} sqs_t;

	typedef struct packed {
		logic [33:0] rem;
		logic        qb;
	} divs_t;

	// one digit of the restoring square root
	function automatic sqs_t sqrt_step(logic [35:0] rem, logic [32:0] root, logic [1:0] pair);
		logic [35:0] sh;
		logic [35:0] trial;
		sqs_t        r;
		sh = {rem[33:0], pair};
		trial = {1'b0, root, 2'b01};
		if (sh >= trial) begin
			r.rem = sh - trial;
			r.root = {root[31:0], 1'b1};
		end else begin
			r.rem = sh;
			r.root = {root[31:0], 1'b0};
		end
		return r;
	endfunction

	// one bit of the restoring division
	function automatic divs_t div_step(logic [33:0] rem, logic nb, logic [32:0] d);
		logic [33:0] sh;
		divs_t       r;
		sh = {rem[32:0], nb};
		if (sh >= {1'b0, d}) begin
			r.rem = sh - {1'b0, d};
			r.qb = 1'b1;
		end else begin
			r.rem = sh;
			r.qb = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [31:0] sat32(logic [34:0] v);
		logic [31:0] r;
		if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
			r = v[31:0];
		end else if (v[34]) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'h7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

/* sv/cci_front.sv */
// Front pipeline: center deltas, squared distance, distance root and case classification.
// Depends on cci_pkg.
module cci_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  cci_pkg::in_t  item,
	input  logic [15:0]   tol,
	output cci_pkg::mid_t mid_word,
	output logic          mid_push,
	input  logic          mid_full
);
	import cci_pkg::*;

	localparam int RT_N = 33;
	localparam int NSTG = RT_N + 4;

	typedef struct packed {
		logic [31:0] x1;
		logic [31:0] y1;
		logic [30:0] r1;
		logic [30:0] r2;
		logic [32:0] dx;
		logic [32:0] dy;
	} fpay_t;

	typedef struct packed {
		fpay_t       p;
		logic [65:0] n;
		logic [35:0] rem;
		logic [32:0] root;
	} frt_t;

	logic [NSTG-1:0] vld_q;
	logic            en;
	fpay_t           p_s1, p_s2, p_s3;
	logic [63:0]     sx_s2, sy_s2;
	logic [65:0]     n_s3;
	frt_t            rt_s [RT_N];
	frt_t            rt_nx [RT_N];
	mid_t            mid_s37;
	mid_t            cls;
	fpay_t           p1;
	logic [31:0]     ux, uy;
	sqs_t            sq;
	logic [32:0]     d;
	logic [31:0]     s;
	logic [33:0]     diff, adiff, sd;
	logic [31:0]     dr, adr;
	logic            tangent, two, bad;

	assign en = !vld_q[NSTG-1] || !mid_full;
	assign full = !en;
	assign mid_push = vld_q[NSTG-1] && !mid_full;
	assign mid_word = mid_s37;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-2:0], push};
		end
	end

	always_comb begin
		p1.x1 = item.first_x;
		p1.y1 = item.first_y;
		p1.r1 = item.first_radius;
		p1.r2 = item.second_radius;
		p1.dx = {item.second_x[31], item.second_x} - {item.first_x[31], item.first_x};
		p1.dy = {item.second_y[31], item.second_y} - {item.first_y[31], item.first_y};
		ux = p_s1.dx[32] ? 32'(33'd0 - p_s1.dx) : p_s1.dx[31:0];
		uy = p_s1.dy[32] ? 32'(33'd0 - p_s1.dy) : p_s1.dy[31:0];
	end

	always_comb begin
		sq = sqrt_step(36'd0, 33'd0, n_s3[65:64]);
		rt_nx[0].p = p_s3;
		rt_nx[0].n = n_s3;
		rt_nx[0].rem = sq.rem;
		rt_nx[0].root = sq.root;
		for (int k = 1; k < RT_N; k++) begin
			sq = sqrt_step(rt_s[k-1].rem, rt_s[k-1].root, rt_s[k-1].n[2*(RT_N-1-k) +: 2]);
			rt_nx[k].p = rt_s[k-1].p;
			rt_nx[k].n = rt_s[k-1].n;
			rt_nx[k].rem = sq.rem;
			rt_nx[k].root = sq.root;
		end
	end

	// classify tangent, overlap, apart or invalid
	always_comb begin
		d = rt_s[RT_N-1].root;
		s = {1'b0, rt_s[RT_N-1].p.r1} + {1'b0, rt_s[RT_N-1].p.r2};
		diff = {1'b0, d} - {2'b0, s};
		adiff = diff[33] ? 34'd0 - diff : diff;
		sd = {2'b0, s} - {1'b0, d};
		tangent = adiff < {18'd0, tol};
		two = $signed(sd) > $signed({18'd0, tol});
		dr = {1'b0, rt_s[RT_N-1].p.r1} - {1'b0, rt_s[RT_N-1].p.r2};
		adr = dr[31] ? 32'd0 - dr : dr;
		bad = (d == 33'd0) || (d < {1'b0, adr});
		cls.x1 = rt_s[RT_N-1].p.x1;
		cls.y1 = rt_s[RT_N-1].p.y1;
		cls.r1 = rt_s[RT_N-1].p.r1;
		cls.dx = rt_s[RT_N-1].p.dx;
		cls.dy = rt_s[RT_N-1].p.dy;
		cls.d = d;
		cls.dr = dr;
		cls.s = s;
		priority if (tangent) begin
			cls.status = (d == 33'd0) ? ST_INVALID : ST_TANGENT;
		end else if (two) begin
			cls.status = bad ? ST_INVALID : ST_TWO;
		end else begin
			cls.status = ST_APART;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= p1;
			p_s2 <= p_s1;
			sx_s2 <= {32'd0, ux} * {32'd0, ux};
			sy_s2 <= {32'd0, uy} * {32'd0, uy};
			p_s3 <= p_s2;
			n_s3 <= {2'b0, sx_s2} + {2'b0, sy_s2};
			for (int k = 0; k < RT_N; k++) begin
				rt_s[k] <= rt_nx[k];
			end
			mid_s37 <= cls;
		end
	end

endmodule

/* sv/cci_queue.sv */
// Short queue of classified words between the front and back pipelines.
// Depends on cci_pkg.
module cci_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cci_pkg::mid_t wr_word,
	output logic          full,
	input  logic          pop,
	output cci_pkg::mid_t rd_word,
	output logic          empty
);
	import cci_pkg::*;

	mid_t           mem_q [MQ_DEPTH];
	logic [MQ_AW-1:0] wr_q, rd_q;
	logic [MQ_AW:0] cnt_q;
	logic           do_push, do_pop;

	assign full = cnt_q == (MQ_AW+1)'(MQ_DEPTH);
	assign empty = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rd_word = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (MQ_AW+1)'(do_push) - (MQ_AW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wr_word;
		end
	end

endmodule

/* sv/cci_back.sv */
// Back pipeline: chord offset division, half-chord root, projection divisions and output queue.
// Depends on cci_pkg.
module cci_back (
	input  logic          clk,
	input  logic          arst_n,
	input  cci_pkg::mid_t mid_word,
	input  logic          mid_empty,
	output logic          mid_pop,
	output cci_pkg::out_t result,
	output logic          empty,
	input  logic          pop
);
	import cci_pkg::*;

	localparam int DV1_N = 32;
	localparam int HR_N = 31;
	localparam int DV2_N = 31;
	localparam int NSTG = DV1_N + HR_N + DV2_N + 11;

	typedef struct packed {
		mid_t        m;
		logic        neg;
		logic [62:0] mag;
		logic [33:0] rem;
		logic [31:0] quo;
	} dv1_t;

	typedef struct packed {
		mid_t        m;
		logic [31:0] a;
		logic [61:0] hd;
		logic [35:0] rem;
		logic [32:0] root;
	} hr_t;

	typedef struct packed {
		mid_t              m;
		logic [3:0]        neg;
		logic [3:0][62:0]  mag;
		logic [3:0][33:0]  rem;
		logic [3:0][30:0]  quo;
	} dv2_t;

	logic [NSTG-1:0]  vld_q;
	logic             en, oq_full, oq_push;
	mid_t             m_s1, m_s2, m_s3, m_s4, m_s5, m_s6, m_s7, m_s8, m_s9, m_s10;
	logic [63:0]      num_s2;
	logic             neg_s3;
	logic [62:0]      mag_s3;
	dv1_t             dv1_s [DV1_N];
	dv1_t             dv1_nx [DV1_N];
	logic [33:0]      q_s4;
	logic [31:0]      a_s5, a_s6, a_s7;
	logic [61:0]      r1sq_s6, asq_s6, hd_s7;
	hr_t              hr_s [HR_N];
	hr_t              hr_nx [HR_N];
	logic [3:0][63:0] prod_s8;
	logic [3:0]       neg_s9;
	logic [3:0][62:0] mag_s9;
	dv2_t             dv2_s [DV2_N];
	dv2_t             dv2_nx [DV2_N];
	logic [3:0][31:0] q_s10;
	out_t             out_s11;
	out_t             oq_q [2];
	logic             oq_wr_q, oq_rd_q;
	logic [1:0]       oq_cnt_q;

	divs_t            dv, dvp;
	sqs_t             sq;
	logic [33:0]      qfix;
	logic [34:0]      mm, asat, r1e;
	logic [30:0]      amag;
	logic [31:0]      ksel;
	logic [30:0]      hsel;
	logic [3:0][63:0] prod;
	logic [3:0][31:0] qs;
	logic [34:0]      px, py, qx, qy, ox, oy;
	out_t             ow;

	assign en = !vld_q[NSTG-1] || !oq_full;
	assign mid_pop = en && !mid_empty;
	assign oq_full = oq_cnt_q == 2'd2;
	assign oq_push = vld_q[NSTG-1] && !oq_full;
	assign empty = oq_cnt_q == 2'd0;
	assign result = oq_q[oq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-2:0], mid_pop};
		end
	end

	// offset division, floor of dr*s/d
	always_comb begin
		dv = div_step({3'b0, mag_s3[62:32]}, mag_s3[31], m_s3.d);
		dv1_nx[0].m = m_s3;
		dv1_nx[0].neg = neg_s3;
		dv1_nx[0].mag = mag_s3;
		dv1_nx[0].rem = dv.rem;
		dv1_nx[0].quo = {31'd0, dv.qb};
		for (int k = 1; k < DV1_N; k++) begin
			dv = div_step(dv1_s[k-1].rem, dv1_s[k-1].mag[DV1_N-1-k], dv1_s[k-1].m.d);
			dv1_nx[k] = dv1_s[k-1];
			dv1_nx[k].rem = dv.rem;
			dv1_nx[k].quo = {dv1_s[k-1].quo[30:0], dv.qb};
		end
		qfix = {2'b0, dv1_s[DV1_N-1].quo} + {33'd0, dv1_s[DV1_N-1].rem != 34'd0};
		if (dv1_s[DV1_N-1].neg) begin
			qfix = 34'd0 - qfix;
		end else begin
			qfix = {2'b0, dv1_s[DV1_N-1].quo};
		end
	end

	// a = floor((d + q) / 2), clamped to the first radius
	always_comb begin
		mm = {2'b0, m_s4.d} + {q_s4[33], q_s4};
		asat = {mm[34], mm[34:1]};
		r1e = {4'b0, m_s4.r1};
		if ($signed(asat) > $signed(r1e)) begin
			asat = r1e;
		end else if ($signed(asat) < $signed(35'd0 - r1e)) begin
			asat = 35'd0 - r1e;
		end
		amag = a_s5[31] ? 31'(32'd0 - a_s5) : a_s5[30:0];
	end

	// half-chord root
	always_comb begin
		sq = sqrt_step(36'd0, 33'd0, hd_s7[61:60]);
		hr_nx[0].m = m_s7;
		hr_nx[0].a = a_s7;
		hr_nx[0].hd = hd_s7;
		hr_nx[0].rem = sq.rem;
		hr_nx[0].root = sq.root;
		for (int k = 1; k < HR_N; k++) begin
			sq = sqrt_step(hr_s[k-1].rem, hr_s[k-1].root, hr_s[k-1].hd[2*(HR_N-1-k) +: 2]);
			hr_nx[k] = hr_s[k-1];
			hr_nx[k].rem = sq.rem;
			hr_nx[k].root = sq.root;
		end
	end

	// projections onto the center line and its normal
	always_comb begin
		if (hr_s[HR_N-1].m.status == ST_TANGENT) begin
			ksel = {1'b0, hr_s[HR_N-1].m.r1};
			hsel = 31'd0;
		end else begin
			ksel = hr_s[HR_N-1].a;
			hsel = hr_s[HR_N-1].root[30:0];
		end
		prod[0] = 64'($signed(ksel) * $signed(hr_s[HR_N-1].m.dx));
		prod[1] = 64'($signed(ksel) * $signed(hr_s[HR_N-1].m.dy));
		prod[2] = 64'($signed({1'b0, hsel}) * $signed(hr_s[HR_N-1].m.dy));
		prod[3] = 64'($signed({1'b0, hsel}) * $signed(hr_s[HR_N-1].m.dx));
	end

	always_comb begin
		dv2_nx[0].m = m_s9;
		dv2_nx[0].neg = neg_s9;
		dv2_nx[0].mag = mag_s9;
		for (int i = 0; i < 4; i++) begin
			dvp = div_step({2'b0, mag_s9[i][62:31]}, mag_s9[i][30], m_s9.d);
			dv2_nx[0].rem[i] = dvp.rem;
			dv2_nx[0].quo[i] = {30'd0, dvp.qb};
		end
		for (int k = 1; k < DV2_N; k++) begin
			dv2_nx[k] = dv2_s[k-1];
			for (int i = 0; i < 4; i++) begin
				dvp = div_step(dv2_s[k-1].rem[i], dv2_s[k-1].mag[i][DV2_N-1-k], dv2_s[k-1].m.d);
				dv2_nx[k].rem[i] = dvp.rem;
				dv2_nx[k].quo[i] = {dv2_s[k-1].quo[i][29:0], dvp.qb};
			end
		end
		for (int i = 0; i < 4; i++) begin
			qs[i] = dv2_s[DV2_N-1].neg[i] ? 32'd0 - {1'b0, dv2_s[DV2_N-1].quo[i]}
				: {1'b0, dv2_s[DV2_N-1].quo[i]};
		end
	end

	// assemble the output points by status: two points, one tangent point or none
	always_comb begin
		qx = {{3{q_s10[0][31]}}, q_s10[0]};
		qy = {{3{q_s10[1][31]}}, q_s10[1]};
		ox = {{3{q_s10[2][31]}}, q_s10[2]};
		oy = {{3{q_s10[3][31]}}, q_s10[3]};
		px = {{3{m_s10.x1[31]}}, m_s10.x1} + qx;
		py = {{3{m_s10.y1[31]}}, m_s10.y1} + qy;
		ow.status = m_s10.status;
		unique case (m_s10.status)
			ST_TANGENT: begin
				ow.point_a_x = sat32(px);
				ow.point_a_y = sat32(py);
				ow.point_b_x = '0;
				ow.point_b_y = '0;
			end
			ST_TWO: begin
				ow.point_a_x = sat32(px + ox);
				ow.point_a_y = sat32(py - oy);
				ow.point_b_x = sat32(px - ox);
				ow.point_b_y = sat32(py + oy);
			end
			ST_APART, ST_INVALID: begin
				ow.point_a_x = '0;
				ow.point_a_y = '0;
				ow.point_b_x = '0;
				ow.point_b_y = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= mid_word;
			m_s2 <= m_s1;
			num_s2 <= 64'($signed(m_s1.dr) * $signed({1'b0, m_s1.s}));
			m_s3 <= m_s2;
			neg_s3 <= num_s2[63];
			mag_s3 <= num_s2[63] ? 63'(64'd0 - num_s2) : num_s2[62:0];
			for (int k = 0; k < DV1_N; k++) begin
				dv1_s[k] <= dv1_nx[k];
			end
			m_s4 <= dv1_s[DV1_N-1].m;
			q_s4 <= qfix;
			m_s5 <= m_s4;
			a_s5 <= asat[31:0];
			m_s6 <= m_s5;
			a_s6 <= a_s5;
			r1sq_s6 <= {31'd0, m_s5.r1} * {31'd0, m_s5.r1};
			asq_s6 <= {31'd0, amag} * {31'd0, amag};
			m_s7 <= m_s6;
			a_s7 <= a_s6;
			hd_s7 <= r1sq_s6 - asq_s6;
			for (int k = 0; k < HR_N; k++) begin
				hr_s[k] <= hr_nx[k];
			end
			m_s8 <= hr_s[HR_N-1].m;
			prod_s8 <= prod;
			m_s9 <= m_s8;
			for (int i = 0; i < 4; i++) begin
				neg_s9[i] <= prod_s8[i][63];
				mag_s9[i] <= prod_s8[i][63] ? 63'(64'd0 - prod_s8[i]) : prod_s8[i][62:0];
			end
			for (int k = 0; k < DV2_N; k++) begin
				dv2_s[k] <= dv2_nx[k];
			end
			m_s10 <= dv2_s[DV2_N-1].m;
			q_s10 <= qs;
			out_s11 <= ow;
		end
		if (oq_push) begin
			oq_q[oq_wr_q] <= out_s11;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q <= 1'b0;
			oq_rd_q <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= !oq_wr_q;
			end
			if (pop && !empty) begin
				oq_rd_q <= !oq_rd_q;
			end
			oq_cnt_q <= oq_cnt_q + 2'(oq_push) - 2'(pop && !empty);
		end
	end

endmodule

/* sv/circle_circle_intersect_top.sv */
// Top level of the circle-circle intersection block: tolerance register,
// front pipeline, word queue and back pipeline. Depends on cci_pkg and the cci modules.
//
// Takes one circle pair per clock while the result side pops, and returns one word per pair, in order.
// A word crosses 37 front stages (deltas, squares, 33-step distance root,
// classification), the 4-word queue, 105 back stages (32-step offset division,
// 31-step half-chord root, four 31-step projection divisions) and the 2-word result
// queue, one register per stage, in that order. Each root and divider step is its own
// pipeline stage, so throughput stays at one pair per cycle while the result side pops.
// A stalled result queue freezes the back pipeline and then, once the middle queue
// fills, the front. Write tolerance only while the block is idle.
module circle_circle_intersect_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  cci_pkg::in_t  item,
	input  logic          pop,
	output logic          empty,
	output cci_pkg::out_t result,
	input  logic          cfg_wen,
	input  logic [15:0]   cfg_wdata
);
	import cci_pkg::*;

	logic [15:0] tol_q;
	mid_t        fw_word, bk_word;
	logic        mid_push, mid_full, mid_pop, mid_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_wen) begin
			tol_q <= cfg_wdata;
		end
	end

	cci_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.tol      (tol_q),
		.mid_word (fw_word),
		.mid_push (mid_push),
		.mid_full (mid_full)
	);

	cci_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (mid_push),
		.wr_word (fw_word),
		.full    (mid_full),
		.pop     (mid_pop),
		.rd_word (bk_word),
		.empty   (mid_empty)
	);

	cci_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_word  (bk_word),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		mid_push |-> !mid_full)
		else $error("front pushed a word into a full middle queue");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status == ST_INVALID) |->
		(result.point_a_x == '0 && result.point_a_y == '0 &&
		 result.point_b_x == '0 && result.point_b_y == '0))
		else $error("invalid word carries nonzero points");

	a_tangent_single: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status == ST_TANGENT) |->
		(result.point_b_x == '0 && result.point_b_y == '0))
		else $error("tangent word carries a second point");

	a_mid_pop_legal: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("back popped an empty middle queue");

endmodule

/* tb/tb_circle_circle_intersect_top.sv */
// Testbench for circle_circle_intersect_top: directed table then random pairs, with
// each word checked by a wide-integer predictor or typed row. Depends on cci_pkg.
`timescale 1ns / 100ps

module tb_circle_circle_intersect_top;
	import cci_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		in_t  pair;
		bit   typed;
		out_t want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	in_t         item;
	logic        pop = 1'b0;
	logic        empty;
	out_t        result;
	logic        cfg_wen;
	logic [15:0] cfg_wdata;

	logic [15:0] tolerance;
	out_t        expected_words[$];
	int          errors = 0;
	int          send_idle;
	int          recv_idle;
	int          phase;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	row_t        rows[$];

	circle_circle_intersect_top dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.pop(pop), .empty(empty), .result(result),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	initial begin
		#20ms;
		$display("tb_circle_circle_intersect_top: FAIL");
		$finish;
	end

	function automatic wide_t floor_root(wide_t n);
		wide_t res;
		wide_t b;
		res = 0;
		b = wide_t'(1) <<< 126;
		while (b > n) b = b >>> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >>> 1) + b;
			end else begin
				res = res >>> 1;
			end
			b = b >>> 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] clamp32(wide_t v);
		if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
		if (v < -64'sh8000_0000) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic out_t predict_intersection(in_t v, logic [15:0] tol_reg);
		wide_t x1, y1, r1, x2, y2, r2, dx, dy, d, s, diff, tol;
		wide_t dr, adr, num, q, m, a, h, px, py, ox, oy;
		wide_t pax, pay, pbx, pby;
		status_t st;
		out_t o;
		x1 = $signed(v.first_x);
		y1 = $signed(v.first_y);
		x2 = $signed(v.second_x);
		y2 = $signed(v.second_y);
		r1 = {97'd0, v.first_radius};
		r2 = {97'd0, v.second_radius};
		tol = {112'd0, tol_reg};
		dx = x2 - x1;
		dy = y2 - y1;
		d = floor_root(dx * dx + dy * dy);
		s = r1 + r2;
		diff = (d > s) ? d - s : s - d;
		pax = 0; pay = 0; pbx = 0; pby = 0;
		st = ST_APART;
		if (diff < tol) begin
			if (d == 0) begin
				st = ST_INVALID;
			end else begin
				pax = x1 + (r1 * dx) / d;
				pay = y1 + (r1 * dy) / d;
				st = ST_TANGENT;
			end
		end else if (s - d > tol) begin
			dr = r1 - r2;
			adr = (dr < 0) ? -dr : dr;
			if (d == 0 || d < adr) begin
				st = ST_INVALID;
			end else begin
				num = dr * s;
				q = num / d;
				if (num % d != 0 && num < 0) q = q - 1;
				m = d + q;
				a = (m >= 0) ? m / 2 : -((-m + 1) / 2);
				if (a > r1) a = r1;
				if (a < -r1) a = -r1;
				h = floor_root(r1 * r1 - a * a);
				px = x1 + (a * dx) / d;
				py = y1 + (a * dy) / d;
				ox = (h * dy) / d;
				oy = (h * dx) / d;
				pax = px + ox;
				pay = py - oy;
				pbx = px - ox;
				pby = py + oy;
				st = ST_TWO;
			end
		end
		o.point_a_x = clamp32(pax);
		o.point_a_y = clamp32(pay);
		o.point_b_x = clamp32(pbx);
		o.point_b_y = clamp32(pby);
		o.status = st;
		return o;
	endfunction

	function automatic in_t make_pair(int x1, int y1, int r1, int x2, int y2, int r2);
		in_t p;
		p.first_x = x1;
		p.first_y = y1;
		p.first_radius = r1[30:0];
		p.second_x = x2;
		p.second_y = y2;
		p.second_radius = r2[30:0];
		return p;
	endfunction

	function automatic out_t make_word(int ax, int ay, status_t st);
		out_t o;
		o.point_a_x = ax;
		o.point_a_y = ay;
		o.point_b_x = 0;
		o.point_b_y = 0;
		o.status = st;
		return o;
	endfunction

	function automatic in_t random_pair();
		in_t p;
		int x1, y1, dx, dy, r1, r2, span, sel;
		wide_t dw;
		sel = $urandom_range(0, 9);
		if (sel < 2) begin
			p.first_x = $urandom;
			p.first_y = $urandom;
			p.first_radius = 31'($urandom);
			p.second_x = $urandom;
			p.second_y = $urandom;
			p.second_radius = 31'($urandom);
			return p;
		end
		x1 = $urandom_range(0, 1 << 23) - (1 << 22);
		y1 = $urandom_range(0, 1 << 23) - (1 << 22);
		dx = $urandom_range(0, 1 << 21) - (1 << 20);
		dy = $urandom_range(0, 1 << 21) - (1 << 20);
		if (sel == 2) dy = 0;
		dw = floor_root(wide_t'(dx) * dx + wide_t'(dy) * dy);
		span = int'(dw);
		r1 = $urandom_range(0, span + 1000);
		case (sel)
			3, 4: r2 = span - r1 + $urandom_range(0, 2 * tolerance + 2) - tolerance - 1;
			5: r2 = span - r1 - $urandom_range(1, 1 << 16);
			9: r2 = $urandom_range(0, 1 << 22);
			default: r2 = span - r1 + $urandom_range(1, span + 1);
		endcase
		if (r2 < 0) r2 = -r2;
		return make_pair(x1, y1, r1, x1 + dx, y1 + dy, r2);
	endfunction

	task automatic send_pair(in_t p);
		while ($urandom_range(0, 99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= p;
		do @(posedge clk); while (full);
		expected_words = {expected_words, predict_intersection(p, tolerance)};
	endtask

	task automatic drain();
		push <= 1'b0;
		wait (expected_words.size() == 0);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [15:0] v);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		tolerance = v;
	endtask

	// result side: check the word at the head, then choose pop for the next edge
	always @(posedge clk) begin
		out_t want;
		if (arst_n && pop && !empty) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word %p", $time, result);
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (result.point_a_x !== want.point_a_x)
					$display("%0t: point_a_x expected %0d got %0d", $time,
						want.point_a_x, result.point_a_x);
				if (result.point_a_y !== want.point_a_y)
					$display("%0t: point_a_y expected %0d got %0d", $time,
						want.point_a_y, result.point_a_y);
				if (result.point_b_x !== want.point_b_x)
					$display("%0t: point_b_x expected %0d got %0d", $time,
						want.point_b_x, result.point_b_x);
				if (result.point_b_y !== want.point_b_y)
					$display("%0t: point_b_y expected %0d got %0d", $time,
						want.point_b_y, result.point_b_y);
				if (result.status !== want.status)
					$display("%0t: status expected %s got %s", $time,
						want.status.name(), result.status.name());
				if (result !== want) errors++;
			end
		end
		if (phase == 4 && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= 600;
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	initial begin
		logic [15:0] tol_list[6];
		int idx;
		phase = -1;
		tolerance = TOL_RESET;
		send_idle = 20;
		recv_idle = 73;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = {rows, row_t'{make_pair(0, 0, 0, 0, 0, 0), 1, make_word(0, 0, ST_INVALID)}};
		rows = {rows, row_t'{make_pair(7, 7, 5 << 16, 7, 7, 5 << 16), 1,
			make_word(0, 0, ST_INVALID)}};
		rows = {rows, row_t'{make_pair(0, 0, 1 << 16, 100 << 16, 0, 1 << 16), 1,
			make_word(0, 0, ST_APART)}};
		rows = {rows, row_t'{make_pair(0, 0, 3 << 16, 5 << 16, 0, 2 << 16), 1,
			make_word(3 << 16, 0, ST_TANGENT)}};
		rows = {rows, row_t'{make_pair(0, 0, 10 << 16, 1 << 16, 0, 1 << 16), 1,
			make_word(0, 0, ST_INVALID)}};
		rows = {rows, row_t'{make_pair(0, 0, 3, 6, 0, 4), 1, make_word(0, 0, ST_APART)}};
		rows = {rows, row_t'{make_pair(0, 0, 5 << 16, 8 << 16, 0, 5 << 16), 0, '0}};
		rows = {rows, row_t'{make_pair(-3 << 16, -4 << 16, 4 << 16, 3 << 16, 4 << 16,
			7 << 16), 0, '0}};
		rows = {rows, row_t'{make_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0, '0}};
		rows = {rows, row_t'{make_pair(32'h8000_0000, 0, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 0, 32'h7FFF_FFFF), 0, '0}};
		rows = {rows, row_t'{make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 0), 0, '0}};
		rows = {rows, row_t'{make_pair(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1), 0, '0}};
		rows = {rows, row_t'{make_pair(100, -200, 50, 100, -150, 30), 0, '0}};

		foreach (rows[i]) begin
			send_pair(rows[i].pair);
			if (rows[i].typed) expected_words[$] = rows[i].want;
		end
		drain();

		tol_list = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd300};
		tol_list[3] = 16'($urandom);
		tol_list[4] = 16'($urandom_range(0, 64));
		for (int p = 0; p < 6; p++) begin
			write_tolerance(tol_list[p]);
			send_idle = (p < 2) ? 20 : (p < 4) ? 73 : 0;
			recv_idle = (p < 2) ? 73 : (p < 4) ? 20 : 0;
			phase = p;
			for (idx = 0; idx < 190; idx++) send_pair(random_pair());
			drain();
		end

		if (errors == 0) begin
			$display("tb_circle_circle_intersect_top: PASS");
		end else begin
			$display("tb_circle_circle_intersect_top: FAIL");
		end
		$finish;
	end

endmodule
